### rtl/dstwr_pkg.sv
package dstwr_pkg;

   localparam int TS_BITS_DEF  = 40;
   localparam int SEQ_BITS_DEF = 16;

   // distance scale: ticks to centimetres in Q0.24
   localparam longint unsigned SCALE_Q24 = 64'd7871474;
   localparam int FRAC_BITS  = 24;
   localparam int SCALE_BITS = $clog2(SCALE_Q24);
   localparam int DIST_BITS  = 16;

   // smallest time of flight whose scaled value no longer fits int16
   localparam longint unsigned SAT_LIMIT =
      ((64'd1 << (FRAC_BITS + DIST_BITS - 1)) + SCALE_Q24 - 64'd1) / SCALE_Q24;
   localparam int QUO_BITS    = $clog2(SAT_LIMIT);
   localparam int SCALED_BITS = QUO_BITS + SCALE_BITS;

   localparam logic signed [DIST_BITS-1:0] DIST_MAX    = 16'sh7FFF;
   localparam logic signed [DIST_BITS-1:0] DIST_MIN    = 16'sh8000;
   localparam logic signed [DIST_BITS-1:0] MAX_DIST_CM = 16'sd1000;
   localparam logic signed [DIST_BITS-1:0] REJECT_CODE = -16'sd1;

   localparam logic FILTER_RESET = 1'b1;

   // flags that ride along with the quotient through the divider
   typedef struct packed {
      logic neg;
      logic sat;
      logic zero;
      logic bad;
   } side_type;

endpackage

### rtl/dstwr_div.sv
module dstwr_div
   import dstwr_pkg::*;
#(
   parameter int DEN_BITS = TS_BITS_DEF + 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [DEN_BITS+QUO_BITS-1:0] in_rem,
   input  logic [DEN_BITS-1:0] in_den,
   input  side_type            in_side,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [QUO_BITS-1:0] out_quo,
   output side_type            out_side
);

   localparam int REM_BITS = DEN_BITS + QUO_BITS;

   logic                v_ff    [QUO_BITS];
   logic [REM_BITS-1:0] rem_ff  [QUO_BITS];
   logic [DEN_BITS-1:0] den_ff  [QUO_BITS];
   logic [QUO_BITS-1:0] quo_ff  [QUO_BITS];
   side_type            side_ff [QUO_BITS];
   logic [QUO_BITS:0]   rdy;

   assign rdy[QUO_BITS] = out_ready;

   // one quotient bit per stage, msb first
   for (genvar j = 0; j < QUO_BITS; j++) begin : g_stage
      logic                v_src;
      logic [REM_BITS-1:0] rem_src;
      logic [DEN_BITS-1:0] den_src;
      logic [QUO_BITS-1:0] quo_src;
      side_type            side_src;
      logic [REM_BITS-1:0] dsh;
      logic                ge;
      logic [REM_BITS-1:0] rem_in;
      logic [QUO_BITS-1:0] quo_in;

      if (j == 0) begin : g_first
         assign v_src    = in_valid;
         assign rem_src  = in_rem;
         assign den_src  = in_den;
         assign quo_src  = '0;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = v_ff[j-1];
         assign rem_src  = rem_ff[j-1];
         assign den_src  = den_ff[j-1];
         assign quo_src  = quo_ff[j-1];
         assign side_src = side_ff[j-1];
      end

      assign rdy[j]  = !v_ff[j] || rdy[j+1];
      assign dsh     = REM_BITS'(den_src) << (QUO_BITS - 1 - j);
      assign ge      = rem_src >= dsh;
      assign rem_in  = ge ? rem_src - dsh : rem_src;
      assign quo_in  = {quo_src[QUO_BITS-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (rdy[j]) begin
            v_ff[j] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[j]) begin
            rem_ff[j]  <= rem_in;
            den_ff[j]  <= den_src;
            quo_ff[j]  <= quo_in;
            side_ff[j] <= side_src;
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[QUO_BITS-1];
   assign out_quo   = quo_ff[QUO_BITS-1];
   assign out_side  = side_ff[QUO_BITS-1];

endmodule

### rtl/ds_twr_distance_unit.sv
// Asymmetric double-sided two-way ranging: each transfer on req_ carries the six timestamps
// and sequence numbers of one poll/reply/final exchange and gives one distance in cm on rsp_,
// saturated to int16, or -1 when the filter (csr_filter_enable, on after reset) sees bad
// sequence numbers or a distance outside 0..1000. The block is a pipeline of 25 register
// stages: six for intervals, split 80-bit products, difference and saturation check,
// seventeen for the restoring divider (one quotient bit per stage), one for the scale
// multiply and the output register. It takes one exchange per cycle while rsp_ready is held
// high; every stage holds its item while the stage after it is full, so a stall loses nothing
// and bubbles close up.
module ds_twr_distance_unit
   import dstwr_pkg::*;
#(
   parameter int TS_BITS  = TS_BITS_DEF,
   parameter int SEQ_BITS = SEQ_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [TS_BITS-1:0]          req_tp_time,
   input  logic [SEQ_BITS-1:0]         req_tp_seq,
   input  logic [TS_BITS-1:0]          req_rp_time,
   input  logic [SEQ_BITS-1:0]         req_rp_seq,
   input  logic [TS_BITS-1:0]          req_tr_time,
   input  logic [SEQ_BITS-1:0]         req_tr_seq,
   input  logic [TS_BITS-1:0]          req_rr_time,
   input  logic [SEQ_BITS-1:0]         req_rr_seq,
   input  logic [TS_BITS-1:0]          req_tf_time,
   input  logic [SEQ_BITS-1:0]         req_tf_seq,
   input  logic [TS_BITS-1:0]          req_rf_time,
   input  logic [SEQ_BITS-1:0]         req_rf_seq,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [DIST_BITS-1:0] rsp_distance_cm,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_filter_enable
);

   localparam int HALF      = (TS_BITS + 1) / 2;
   localparam int HI_BITS   = TS_BITS - HALF;
   localparam int PROD_BITS = 2 * TS_BITS;
   localparam int DEN_BITS  = TS_BITS + 2;
   localparam int REM_BITS  = DEN_BITS + QUO_BITS;
   localparam int CMP_BITS  = (PROD_BITS > REM_BITS) ? PROD_BITS : REM_BITS;
   localparam logic [REM_BITS-1:0]    LIM_K   = REM_BITS'(SAT_LIMIT);
   localparam logic [SCALED_BITS-1:0] SCALE_K = SCALED_BITS'(SCALE_Q24);

   // handshake chain, last stage first
   logic rdy_out, rdy_m, rdy6, rdy5, rdy4, rdy3, rdy2, rdy1;
   logic div_in_ready, div_out_valid;
   logic [QUO_BITS-1:0] div_quo;
   side_type            div_side;

   logic filter_ff;

   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, s6_v_ff, sm_v_ff, rsp_valid_ff;

   // stage 1: wrapped intervals, sequence check
   logic [TS_BITS-1:0] iv_in [4];
   logic [TS_BITS-1:0] iv_ff [4];
   logic               s1_bad_in, s1_bad_ff;

   // stage 2: partial products and interval sum
   logic [2*HALF-1:0]    ll_in [2];
   logic [2*HALF-1:0]    ll_ff [2];
   logic [TS_BITS-1:0]   lh_in [2];
   logic [TS_BITS-1:0]   lh_ff [2];
   logic [TS_BITS-1:0]   hl_in [2];
   logic [TS_BITS-1:0]   hl_ff [2];
   logic [2*HI_BITS-1:0] hh_in [2];
   logic [2*HI_BITS-1:0] hh_ff [2];
   logic [DEN_BITS-1:0]  s2_den_in, s2_den_ff;
   logic                 s2_bad_ff;

   // stage 3: full products
   logic [PROD_BITS-1:0] prod_in [2];
   logic [PROD_BITS-1:0] prod_ff [2];
   logic [DEN_BITS-1:0]  s3_den_ff;
   logic                 s3_bad_ff;

   // stage 4: signed difference
   logic [PROD_BITS:0]  diff_in, diff_ff;
   logic [DEN_BITS-1:0] s4_den_ff;
   logic                s4_bad_ff;

   // stage 5: magnitude and saturation limit
   logic [PROD_BITS:0]   diff_neg;
   logic [PROD_BITS-1:0] mag_in, mag_ff;
   logic [REM_BITS-1:0]  lim_in, lim_ff;
   logic                 s5_neg_in, s5_neg_ff;
   logic                 s5_zero_in, s5_zero_ff;
   logic [DEN_BITS-1:0]  s5_den_ff;
   logic                 s5_bad_ff;

   // stage 6: divider operands
   logic [CMP_BITS-1:0] mag_c, lim_c;
   logic [REM_BITS-1:0] rem_in, rem_ff;
   logic [DEN_BITS-1:0] s6_den_ff;
   side_type            s6_side_in, s6_side_ff;

   // scale multiply
   logic [SCALED_BITS-1:0] scaled_in, scaled_ff;
   side_type               sm_side_ff;

   // output
   logic [DIST_BITS-1:0]        scaled_cm;
   logic signed [DIST_BITS-1:0] dist_cm;
   logic                        reject;
   logic signed [DIST_BITS-1:0] rsp_distance_cm_in, rsp_distance_cm_ff;

   assign rdy_out   = !rsp_valid_ff || rsp_ready;
   assign rdy_m     = !sm_v_ff || rdy_out;
   assign rdy6      = !s6_v_ff || div_in_ready;
   assign rdy5      = !s5_v_ff || rdy6;
   assign rdy4      = !s4_v_ff || rdy5;
   assign rdy3      = !s3_v_ff || rdy4;
   assign rdy2      = !s2_v_ff || rdy3;
   assign rdy1      = !s1_v_ff || rdy2;
   assign req_ready = rdy1;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff    <= FILTER_RESET;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         s4_v_ff      <= 1'b0;
         s5_v_ff      <= 1'b0;
         s6_v_ff      <= 1'b0;
         sm_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) filter_ff <= csr_filter_enable;
         if (rdy1)    s1_v_ff      <= req_valid;
         if (rdy2)    s2_v_ff      <= s1_v_ff;
         if (rdy3)    s3_v_ff      <= s2_v_ff;
         if (rdy4)    s4_v_ff      <= s3_v_ff;
         if (rdy5)    s5_v_ff      <= s4_v_ff;
         if (rdy6)    s6_v_ff      <= s5_v_ff;
         if (rdy_m)   sm_v_ff      <= div_out_valid;
         if (rdy_out) rsp_valid_ff <= sm_v_ff;
      end
   end

   // stage 1
   always_comb begin
      iv_in[0]  = req_rr_time - req_tp_time;   // round1
      iv_in[1]  = req_tr_time - req_rp_time;   // reply1
      iv_in[2]  = req_rf_time - req_tr_time;   // round2
      iv_in[3]  = req_tf_time - req_rr_time;   // reply2
      s1_bad_in = (req_tp_seq != req_rp_seq) || (req_tr_seq != req_rr_seq) ||
                  (req_tf_seq != req_rf_seq) || (req_tp_seq >= req_tf_seq) ||
                  (req_rp_seq >= req_rf_seq);
   end

   // stage 2: product 0 is round1*round2, product 1 is reply1*reply2
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         ll_in[k] = {{HALF{1'b0}}, iv_ff[k][HALF-1:0]} *
                    {{HALF{1'b0}}, iv_ff[k+2][HALF-1:0]};
         lh_in[k] = {{HI_BITS{1'b0}}, iv_ff[k][HALF-1:0]} *
                    {{HALF{1'b0}}, iv_ff[k+2][TS_BITS-1:HALF]};
         hl_in[k] = {{HALF{1'b0}}, iv_ff[k][TS_BITS-1:HALF]} *
                    {{HI_BITS{1'b0}}, iv_ff[k+2][HALF-1:0]};
         hh_in[k] = {{HI_BITS{1'b0}}, iv_ff[k][TS_BITS-1:HALF]} *
                    {{HI_BITS{1'b0}}, iv_ff[k+2][TS_BITS-1:HALF]};
      end
      s2_den_in = DEN_BITS'(iv_ff[0]) + DEN_BITS'(iv_ff[1]) +
                  DEN_BITS'(iv_ff[2]) + DEN_BITS'(iv_ff[3]);
   end

   // stage 3
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         prod_in[k] = PROD_BITS'(ll_ff[k]) +
                      (PROD_BITS'(lh_ff[k]) << HALF) +
                      (PROD_BITS'(hl_ff[k]) << HALF) +
                      (PROD_BITS'(hh_ff[k]) << (2 * HALF));
      end
   end

   // stage 4
   assign diff_in = {1'b0, prod_ff[0]} - {1'b0, prod_ff[1]};

   // stage 5
   assign diff_neg   = -diff_ff;
   assign s5_neg_in  = diff_ff[PROD_BITS];
   assign mag_in     = s5_neg_in ? diff_neg[PROD_BITS-1:0] : diff_ff[PROD_BITS-1:0];
   assign lim_in     = REM_BITS'(s4_den_ff) * LIM_K;
   assign s5_zero_in = (s4_den_ff == '0);

   // stage 6: below the limit the quotient fits the divider width
   assign mag_c           = CMP_BITS'(mag_ff);
   assign lim_c           = CMP_BITS'(lim_ff);
   assign rem_in          = mag_c[REM_BITS-1:0];
   assign s6_side_in.neg  = s5_neg_ff;
   assign s6_side_in.sat  = !s5_zero_ff && (mag_c >= lim_c);
   assign s6_side_in.zero = s5_zero_ff;
   assign s6_side_in.bad  = s5_bad_ff;

   always_ff @(posedge clock) begin
      if (rdy1) begin
         iv_ff     <= iv_in;
         s1_bad_ff <= s1_bad_in;
      end
      if (rdy2) begin
         ll_ff     <= ll_in;
         lh_ff     <= lh_in;
         hl_ff     <= hl_in;
         hh_ff     <= hh_in;
         s2_den_ff <= s2_den_in;
         s2_bad_ff <= s1_bad_ff;
      end
      if (rdy3) begin
         prod_ff   <= prod_in;
         s3_den_ff <= s2_den_ff;
         s3_bad_ff <= s2_bad_ff;
      end
      if (rdy4) begin
         diff_ff   <= diff_in;
         s4_den_ff <= s3_den_ff;
         s4_bad_ff <= s3_bad_ff;
      end
      if (rdy5) begin
         mag_ff     <= mag_in;
         lim_ff     <= lim_in;
         s5_neg_ff  <= s5_neg_in;
         s5_zero_ff <= s5_zero_in;
         s5_den_ff  <= s4_den_ff;
         s5_bad_ff  <= s4_bad_ff;
      end
      if (rdy6) begin
         rem_ff     <= rem_in;
         s6_den_ff  <= s5_den_ff;
         s6_side_ff <= s6_side_in;
      end
      if (rdy_m) begin
         scaled_ff  <= scaled_in;
         sm_side_ff <= div_side;
      end
      if (rdy_out) begin
         rsp_distance_cm_ff <= rsp_distance_cm_in;
      end
   end

   dstwr_div #(
      .DEN_BITS (DEN_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s6_v_ff),
      .in_ready  (div_in_ready),
      .in_rem    (rem_ff),
      .in_den    (s6_den_ff),
      .in_side   (s6_side_ff),
      .out_valid (div_out_valid),
      .out_ready (rdy_m),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   // a zero divisor leaves all ones in the quotient, forced to zero here
   assign scaled_in = div_side.zero ? '0 : SCALED_BITS'(div_quo) * SCALE_K;

   always_comb begin
      scaled_cm = scaled_ff[FRAC_BITS +: DIST_BITS];
      if (sm_side_ff.sat) begin
         dist_cm = sm_side_ff.neg ? DIST_MIN : DIST_MAX;
      end else if (sm_side_ff.neg) begin
         dist_cm = -$signed(scaled_cm);
      end else begin
         dist_cm = $signed(scaled_cm);
      end
      reject = filter_ff && (sm_side_ff.bad || (dist_cm < 0) || (dist_cm > MAX_DIST_CM));
      rsp_distance_cm_in = reject ? REJECT_CODE : dist_cm;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance_cm = rsp_distance_cm_ff;

endmodule

### bench/ds_twr_distance_unit_tb.sv
module ds_twr_distance_unit_tb;
   import dstwr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TSW = 40;
   localparam int SQW = 16;
   localparam longint unsigned TICK_TO_CM_Q24 = 64'd7871474;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_PER_PHASE = 500;

   typedef struct packed {
      logic [TSW-1:0] tp_time;
      logic [SQW-1:0] tp_seq;
      logic [TSW-1:0] rp_time;
      logic [SQW-1:0] rp_seq;
      logic [TSW-1:0] tr_time;
      logic [SQW-1:0] tr_seq;
      logic [TSW-1:0] rr_time;
      logic [SQW-1:0] rr_seq;
      logic [TSW-1:0] tf_time;
      logic [SQW-1:0] tf_seq;
      logic [TSW-1:0] rf_time;
      logic [SQW-1:0] rf_seq;
   } exch_type;

   typedef struct {
      exch_type              x;
      bit                    pinned;
      logic signed [15:0]    want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   exch_type req_x = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [DIST_BITS-1:0] rsp_distance_cm;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_value = 1'b0;

   // typed-in result for directed rows, moves with the payload
   bit pin_use = 1'b0;
   logic signed [15:0] pin_dist = '0;

   bit calm = 1'b0;
   bit filt_q = 1'b1;
   logic signed [15:0] dist_due[$];
   int faults = 0;
   int shown = 0;
   int quiet = 0;
   row_type plan[$];

   always #4 clock = ~clock;

   ds_twr_distance_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_tp_time       (req_x.tp_time),
      .req_tp_seq        (req_x.tp_seq),
      .req_rp_time       (req_x.rp_time),
      .req_rp_seq        (req_x.rp_seq),
      .req_tr_time       (req_x.tr_time),
      .req_tr_seq        (req_x.tr_seq),
      .req_rr_time       (req_x.rr_time),
      .req_rr_seq        (req_x.rr_seq),
      .req_tf_time       (req_x.tf_time),
      .req_tf_seq        (req_x.tf_seq),
      .req_rf_time       (req_x.rf_time),
      .req_rf_seq        (req_x.rf_seq),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_distance_cm   (rsp_distance_cm),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_filter_enable (csr_value)
   );

   // distance in cm of one exchange, with the filter as given
   function automatic logic signed [15:0] range_cm(exch_type x, bit filt);
      logic [TSW-1:0] round1, reply1, round2, reply2;
      logic [TSW+1:0] den;
      logic [2*TSW-1:0] prod_a, prod_b, num, mag;
      logic [63:0] scaled;
      logic neg;
      logic signed [15:0] d;
      round1 = x.rr_time - x.tp_time;
      reply1 = x.tr_time - x.rp_time;
      round2 = x.rf_time - x.tr_time;
      reply2 = x.tf_time - x.rr_time;
      den = {2'b00, round1} + round2 + reply1 + reply2;
      prod_a = round1 * round2;
      prod_b = reply1 * reply2;
      neg = prod_a < prod_b;
      num = neg ? prod_b - prod_a : prod_a - prod_b;
      mag = (den == 0) ? '0 : num / den;
      if (mag >= (80'd1 << 40)) begin
         d = neg ? DIST_MIN : DIST_MAX;
      end else begin
         scaled = ({24'd0, mag[39:0]} * TICK_TO_CM_Q24) >> FRAC_BITS;
         if (neg) d = (scaled >= 64'd32768) ? DIST_MIN : -$signed(scaled[15:0]);
         else d = (scaled > 64'd32767) ? DIST_MAX : $signed(scaled[15:0]);
      end
      if (filt) begin
         if (x.tp_seq != x.rp_seq || x.tr_seq != x.rr_seq || x.tf_seq != x.rf_seq ||
             x.tp_seq >= x.tf_seq || x.rp_seq >= x.rf_seq || d < 0 || d > MAX_DIST_CM)
            d = REJECT_CODE;
      end
      return d;
   endfunction

   // one physically consistent exchange: round = reply + twice the flight time
   function automatic exch_type shaped(logic [TSW-1:0] tp, logic [TSW-1:0] rp,
                                       logic [TSW-1:0] reply1, logic [TSW-1:0] reply2,
                                       int tof, logic [SQW-1:0] s);
      exch_type x;
      logic [TSW-1:0] fl;
      fl = 40'(tof) << 1;
      x.tp_time = tp;
      x.rp_time = rp;
      x.tr_time = rp + reply1;
      x.rr_time = tp + reply1 + fl;
      x.tf_time = x.rr_time + reply2;
      x.rf_time = x.tr_time + reply2 + fl;
      x.tp_seq = s;
      x.rp_seq = s;
      x.tr_seq = s + 16'd1;
      x.rr_seq = s + 16'd1;
      x.tf_seq = s + 16'd2;
      x.rf_seq = s + 16'd2;
      return x;
   endfunction

   function automatic exch_type with_seq(exch_type x, logic [SQW-1:0] a, logic [SQW-1:0] b,
                                         logic [SQW-1:0] c, logic [SQW-1:0] d,
                                         logic [SQW-1:0] e, logic [SQW-1:0] f);
      x.tp_seq = a;
      x.rp_seq = b;
      x.tr_seq = c;
      x.rr_seq = d;
      x.tf_seq = e;
      x.rf_seq = f;
      return x;
   endfunction

   function automatic logic [TSW-1:0] rnd_ts();
      return 40'({$urandom, $urandom});
   endfunction

   function automatic exch_type random_exchange();
      exch_type x;
      logic [$bits(exch_type)-1:0] v;
      logic [SQW-1:0] flip;
      int kind, tof;
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
         if ($urandom_range(0, 9) < 8) tof = $urandom_range(0, 2300);
         else tof = int'($urandom_range(0, 200000)) - 100000;
         x = shaped(rnd_ts(), rnd_ts(), rnd_ts() >> $urandom_range(4, 39),
                    rnd_ts() >> $urandom_range(4, 39), tof, 16'($urandom_range(0, 65533)));
         // broken sequence numbers
         if (kind >= 70) begin
            flip = 16'($urandom_range(1, 65535));
            case ($urandom_range(0, 5))
               0: x.rp_seq ^= flip;
               1: x.rr_seq ^= flip;
               2: x.rf_seq ^= flip;
               3: begin
                  x.tf_seq = x.tp_seq;
                  x.rf_seq = x.rp_seq;
               end
               4: x.tp_seq ^= flip;
               default: x.tr_seq ^= flip;
            endcase
         end
      end else begin
         v = '0;
         for (int i = 0; i < 11; i++) v = {v[$bits(exch_type)-33:0], $urandom};
         x = v;
      end
      return x;
   endfunction

   task automatic push(exch_type x, bit pinned, logic signed [15:0] want);
      while (!calm && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_x <= x;
      pin_use <= pinned;
      pin_dist <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_filter(bit v);
      req_valid <= 1'b0;
      // let the last transfer reach the expected queue first
      @(posedge clock);
      while (dist_due.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_value <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 33);
   end

   // reference side: expected distances, result check and watchdog
   always @(posedge clock) begin
      logic signed [15:0] w;
      bit moved;
      if (reset) begin
         filt_q = FILTER_RESET;
         quiet = 0;
      end else begin
         moved = 1'b0;
         if (csr_valid && csr_ready) begin
            filt_q = csr_value;
            moved = 1'b1;
         end
         if (req_valid && req_ready) begin
            dist_due.push_back(pin_use ? pin_dist : range_cm(req_x, filt_q));
            moved = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            if (dist_due.size() == 0) begin
               faults++;
               if (shown < 10) $display("distance %0d with none pending", rsp_distance_cm);
               shown++;
            end else begin
               w = dist_due.pop_front();
               if (rsp_distance_cm !== w) begin
                  faults++;
                  if (shown < 10) $display("distance %0d, wanted %0d", rsp_distance_cm, w);
                  shown++;
               end
            end
         end
         quiet = moved ? 0 : quiet + 1;
         if (quiet >= STALL_LIMIT) begin
            $display("ds_twr_distance_unit: mismatch");
            $finish;
         end
      end
   end

   initial begin
      exch_type t;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      plan.push_back('{with_seq('0, 0, 0, 0, 0, 0, 0), 1, REJECT_CODE});
      // all intervals zero: no divisor, distance zero
      plan.push_back('{with_seq('0, 1, 1, 2, 2, 3, 3), 1, 16'sd0});
      plan.push_back('{'1, 1, REJECT_CODE});
      plan.push_back('{with_seq('1, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1, 16'sd0});
      // every interval at its maximum, products cancel
      plan.push_back('{shaped('0, '0, '1, '1, 0, 16'd1), 1, 16'sd0});
      plan.push_back('{shaped(40'h12_3456_789A, 40'h00_0000_1000, 40'd300000, 40'd450000,
                              1000, 16'd7), 0, 0});
      plan.push_back('{shaped(40'h00_0F00_0000, 40'h55_0000_0000, 40'd123456, 40'd654321,
                              2131, 16'd9), 0, 0});
      plan.push_back('{shaped(40'h00_0F00_0000, 40'h55_0000_0000, 40'd123456, 40'd654321,
                              2133, 16'd9), 0, 0});
      plan.push_back('{shaped(40'h00_0F00_0000, 40'h55_0000_0000, 40'd123456, 40'd654321,
                              2134, 16'd9), 0, 0});
      plan.push_back('{shaped(40'h01_0000_0000, 40'h02_0000_0000, 40'd80000, 40'd90000,
                              -100, 16'd3), 1, REJECT_CODE});
      // huge flight times saturate, then the filter rejects
      plan.push_back('{shaped('0, '0, '0, '0, 32'h4000_0000, 16'd3), 1, REJECT_CODE});
      t = '0;
      t.tr_time = 40'h80_0000_0000;
      t.rf_time = 40'h80_0000_0000;
      t.tf_time = 40'h80_0000_0000;
      plan.push_back('{with_seq(t, 1, 1, 2, 2, 3, 3), 1, REJECT_CODE});
      plan.push_back('{shaped(40'hFF_FFFF_FF00, 40'hFF_FFFF_F000, 40'd5000, 40'd7000,
                              1500, 16'd100), 0, 0});
      plan.push_back('{shaped('1, '1, 40'hFF_FFFF_FFFC, 40'hFF_FFFF_FFF0, 40, 16'd2), 0, 0});
      plan.push_back('{shaped('0, '0, 40'd3000, 40'd3000, 69840, 16'd50), 0, 0});
      plan.push_back('{shaped('0, '0, 40'd3000, 40'd3000, 69845, 16'd50), 0, 0});
      plan.push_back('{shaped('0, '0, 40'd3000, 40'd3000, -69845, 16'd50), 0, 0});
      t = shaped(40'd1000, 40'd2000, 40'd40000, 40'd50000, 1000, 16'd20);
      plan.push_back('{with_seq(t, 20, 21, 21, 21, 22, 22), 1, REJECT_CODE});
      plan.push_back('{with_seq(t, 20, 20, 21, 25, 22, 22), 1, REJECT_CODE});
      plan.push_back('{with_seq(t, 20, 20, 21, 21, 22, 30), 1, REJECT_CODE});
      // final not after poll
      plan.push_back('{with_seq(t, 5, 5, 6, 6, 5, 5), 1, REJECT_CODE});
      plan.push_back('{with_seq(t, 16'hFFFF, 16'hFFFF, 0, 0, 1, 1), 1, REJECT_CODE});
      plan.push_back('{with_seq(t, 16'hFFFD, 16'hFFFD, 16'hFFFE, 16'hFFFE, 16'hFFFF, 16'hFFFF),
                       0, 0});

      write_filter(1'b1);
      foreach (plan[i]) push(plan[i].x, plan[i].pinned, plan[i].want);

      // same rows with the filter off, all predicted
      write_filter(1'b0);
      foreach (plan[i]) push(plan[i].x, 1'b0, 0);

      write_filter(1'b1);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
         calm = (i < RANDOM_PER_PHASE / 2);
         push(random_exchange(), 1'b0, 0);
      end
      calm = 1'b0;

      write_filter(1'b0);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) push(random_exchange(), 1'b0, 0);

      write_filter(1'b1);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) push(random_exchange(), 1'b0, 0);

      req_valid <= 1'b0;
      @(posedge clock);
      while (dist_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (dist_due.size() != 0) faults++;
      if (faults == 0) begin
         $display("ds_twr_distance_unit: match");
      end else begin
         $display("ds_twr_distance_unit: mismatch");
      end
      $finish;
   end

endmodule
